[design/sdm_pkg.sv]
// Shared constants and types for the signed division magic number block.
`default_nettype none

package sdm_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned QuotBits  = WordBits + 2;
  localparam int unsigned CntBits   = $clog2(WordBits);
  localparam int unsigned PBits     = $clog2(2 * WordBits);
  localparam int unsigned ShiftBits = 5;

  localparam logic [PBits-1:0] MaxP = PBits'(2 * WordBits - 1);

  typedef struct packed {
    logic clr;
    logic en;
    logic din;
  } sdm_step_t;

endpackage

`default_nettype wire

[design/sdm_if.sv]
// Request and result channel interfaces for the magic number block.
`default_nettype none

interface sdm_req_if import sdm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface

interface sdm_rsp_if import sdm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] magic;
  logic [ShiftBits-1:0]       shift_amount;
  logic                       add_needed;
  logic                       invalid;

  modport source (output valid, output magic, output shift_amount, output add_needed,
                  output invalid, input ready);
  modport sink   (input valid, input magic, input shift_amount, input add_needed,
                  input invalid, output ready);
endinterface

`default_nettype wire

[design/sdm_serdiv.sv]
// Bit-serial restoring divider: one quotient bit per enabled cycle.
`default_nettype none

module sdm_serdiv import sdm_pkg::*; #(
  parameter int unsigned Width  = WordBits,
  parameter int unsigned QWidth = WordBits
) (
  input  wire logic              clk_i,
  input  wire sdm_step_t         step_i,
  input  wire logic [Width-1:0]  den_i,
  output logic      [Width-1:0]  rem_o,
  output logic      [QWidth-1:0] quo_o
);

  logic [Width-1:0]  rem_q, rem_d;
  logic [QWidth-1:0] quo_q, quo_d;
  logic [Width:0]    shifted;
  logic [Width:0]    diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q, step_i.din};
    diff    = shifted - {1'b0, den_i};
    ge      = shifted >= {1'b0, den_i};
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (step_i.clr) begin
      rem_d = '0;
      quo_d = '0;
    end else if (step_i.en) begin
      rem_d = ge ? diff[Width-1:0] : shifted[Width-1:0];
      quo_d = {quo_q[QWidth-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

[design/signed_division_magic_number.sv]
// Signed division magic number generator: top level.
//
// Takes one divisor request at a time and returns the magic multiplier, the post-shift
// and the add flag for replacing signed division by that constant with a multiply-high.
// Divisors -1, 0, 1 and -2^31 return invalid = 1 with all other fields zero; such a
// request skips the divisions and goes straight to loading the result. Any other divisor
// runs 2^31 / |d|, forms anc, runs 2^31 / anc, takes 1 to 32 search steps, leaves the
// search and loads the result. Loading the result waits while the previous result is
// still held. Both divisions and the search run on bit-serial restoring dividers that
// retire one quotient bit per cycle. The result sits in an output register, so a new
// request is taken as soon as the engine is free, even while the last result waits.
`default_nettype none

module signed_division_magic_number import sdm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdm_req_if.sink   req_i,
  sdm_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDivA,
    StAnc,
    StDivB,
    StLoop,
    StFin
  } state_e;

  state_e               state_q;
  logic [CntBits-1:0]   cnt_q;
  logic [PBits-1:0]     p_q;
  logic                 first_q;
  logic                 neg_q;
  logic                 bad_q;
  logic [WordBits-1:0]  ad_q;
  logic [WordBits-1:0]  anc_q;

  logic                 rsp_valid_q;
  logic [WordBits-1:0]  magic_q;
  logic [ShiftBits-1:0] shift_q;
  logic                 add_q;
  logic                 inv_q;

  sdm_step_t            step1, step2;
  logic [WordBits-1:0]  r1, r2;
  logic [QuotBits-1:0]  q1;
  logic [WordBits-1:0]  q2;

  logic [WordBits-1:0]  din_abs;
  logic                 din_bad;
  logic [WordBits-1:0]  delta;
  logic                 cont;
  logic                 stepping;
  logic [WordBits:0]    tmod;
  logic [WordBits-1:0]  tmod_w;
  logic [WordBits-1:0]  anc_d;
  logic [WordBits-1:0]  magic_d;
  logic [PBits-1:0]     p_off;
  logic                 last_bit;
  logic                 out_free;

  assign req_i.ready = (state_q == StIdle);

  always_comb begin
    din_abs = req_i.divisor[WordBits-1] ? (~req_i.divisor + 1'b1) : req_i.divisor;
    din_bad = (req_i.divisor == '0)
           || (req_i.divisor == WordBits'(1))
           || (req_i.divisor == '1)
           || (req_i.divisor == {1'b1, {(WordBits-1){1'b0}}});

    delta    = ad_q - r2;
    cont     = (q1 < {2'b00, delta}) || ((q1 == {2'b00, delta}) && (r1 == '0));
    stepping = (state_q == StLoop) && (first_q || (cont && (p_q != MaxP)));
    last_bit = (cnt_q == CntBits'(WordBits - 1));

    // t mod ad from 2^31 mod ad, with t one larger for negative divisors
    tmod   = {1'b0, r2} + {{WordBits{1'b0}}, neg_q};
    tmod_w = (tmod == {1'b0, ad_q}) ? '0 : tmod[WordBits-1:0];
    anc_d  = ({1'b0, {(WordBits-1){1'b1}}} + {{(WordBits-1){1'b0}}, neg_q}) - tmod_w;

    step2.clr = req_i.valid && req_i.ready;
    step2.en  = (state_q == StDivA) || stepping;
    step2.din = (state_q == StDivA) && (cnt_q == '0);

    step1.clr = (state_q == StAnc);
    step1.en  = (state_q == StDivB) || stepping;
    step1.din = (state_q == StDivB) && (cnt_q == '0);

    magic_d  = neg_q ? ~q2 : (q2 + 1'b1);
    p_off    = p_q - PBits'(WordBits);
    out_free = !rsp_valid_q || rsp_o.ready;
  end

  sdm_serdiv #(
    .Width  (WordBits),
    .QWidth (QuotBits)
  ) u_div_anc (
    .clk_i  (clk_i),
    .step_i (step1),
    .den_i  (anc_q),
    .rem_o  (r1),
    .quo_o  (q1)
  );

  sdm_serdiv #(
    .Width  (WordBits),
    .QWidth (WordBits)
  ) u_div_ad (
    .clk_i  (clk_i),
    .step_i (step2),
    .den_i  (ad_q),
    .rem_o  (r2),
    .quo_o  (q2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      p_q         <= '0;
      first_q     <= 1'b0;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      ad_q        <= '0;
      anc_q       <= '0;
      rsp_valid_q <= 1'b0;
      magic_q     <= '0;
      shift_q     <= '0;
      add_q       <= 1'b0;
      inv_q       <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && (state_q != StFin)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            neg_q   <= req_i.divisor[WordBits-1];
            ad_q    <= din_abs;
            bad_q   <= din_bad;
            cnt_q   <= '0;
            state_q <= din_bad ? StFin : StDivA;
          end
        end
        StDivA: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_bit) begin
            state_q <= StAnc;
          end
        end
        StAnc: begin
          anc_q   <= anc_d;
          cnt_q   <= '0;
          state_q <= StDivB;
        end
        StDivB: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_bit) begin
            first_q <= 1'b1;
            p_q     <= PBits'(WordBits - 1);
            state_q <= StLoop;
          end
        end
        StLoop: begin
          if (stepping) begin
            first_q <= 1'b0;
            p_q     <= p_q + 1'b1;
          end else begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            rsp_valid_q <= 1'b1;
            inv_q       <= bad_q;
            magic_q     <= bad_q ? '0 : magic_d;
            shift_q     <= bad_q ? '0 : p_off[ShiftBits-1:0];
            add_q       <= !bad_q && !neg_q && magic_d[WordBits-1];
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.magic        = magic_q;
  assign rsp_o.shift_amount = shift_q;
  assign rsp_o.add_needed   = add_q;
  assign rsp_o.invalid      = inv_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && inv_q) |-> (magic_q == '0 && shift_q == '0 && !add_q))
    else $error("invalid result carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && add_q) |-> magic_q[WordBits-1])
    else $error("add flag set with non-negative magic");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivB) |-> (anc_q != '0))
    else $error("anc divider running with zero denominator");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoop) |-> (r2 < ad_q && r1 < anc_q && p_q <= MaxP))
    else $error("search remainder or step count out of range");

endmodule

`default_nettype wire
